FILE: hdl/yuvargb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package yuvargb_pkg;

  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int DIM_FULL_W = 14;
  localparam int ADDR_W     = 25;
  localparam int CHROMA_W   = 22;
  localparam int WORD_W     = 32;
  localparam int PROD_W     = 27;
  localparam int FRAC_BITS  = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_LINE_STRIDE  = 2'd2,
    CFG_ALPHA_VALUE  = 2'd3
  } cfg_idx_t;

  localparam logic [12:0] FRAME_WIDTH_RST  = 13'd1280;
  localparam logic [12:0] FRAME_HEIGHT_RST = 13'd720;
  localparam logic [12:0] LINE_STRIDE_RST  = 13'd1280;
  localparam logic [7:0]  ALPHA_VALUE_RST  = 8'd255;

  localparam logic signed [PROD_W-1:0] COEF_RV = 27'sd18675;
  localparam logic signed [PROD_W-1:0] COEF_GU = 27'sd6466;
  localparam logic signed [PROD_W-1:0] COEF_GV = 27'sd9513;
  localparam logic signed [PROD_W-1:0] COEF_BU = 27'sd33294;
  localparam logic [7:0] LUMA_OFFSET   = 8'd16;
  localparam logic [7:0] CHROMA_OFFSET = 8'd128;

  typedef struct packed {
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic [12:0] line_stride;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   fb_address;
    logic [CHROMA_W-1:0] chroma_index;
    logic                frame_end;
  } raster_t;

  // Even-valued dimension, clamped to 2..max_v.
  function automatic logic [DIM_FULL_W-1:0] eff_dim(input logic [12:0] reg_v,
                                                    input logic [DIM_FULL_W-1:0] max_v);
    logic [DIM_FULL_W-1:0] v;
    v = {1'b0, reg_v[12:1], 1'b0};
    if (v < 14'd2) v = 14'd2;
    if (v > max_v) v = max_v;
    v[0] = 1'b0;
    if (v < 14'd2) v = 14'd2;
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/yuvargb_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface yuvargb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma;
  logic [7:0] chroma_u;
  logic [7:0] chroma_v;

  modport source(output valid, output luma, output chroma_u, output chroma_v, input ready);
  modport sink(input valid, input luma, input chroma_u, input chroma_v, output ready);
endinterface

interface yuvargb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_word;
  logic [24:0] fb_address;
  logic [21:0] chroma_index;
  logic        frame_end;

  modport source(output valid, output pixel_word, output fb_address, output chroma_index,
                 output frame_end, input ready);
  modport sink(input valid, input pixel_word, input fb_address, input chroma_index,
               input frame_end, output ready);
endinterface

`default_nettype wire

FILE: hdl/yuvargb_colour.sv
`timescale 1ns / 1ps
`default_nettype none

module yuvargb_colour
  import yuvargb_pkg::*;
(
  input  wire logic [7:0]        luma,
  input  wire logic [7:0]        chroma_u,
  input  wire logic [7:0]        chroma_v,
  input  wire logic [7:0]        alpha_value,
  output logic      [WORD_W-1:0] pixel_word
);

  function automatic logic [7:0] clamp_byte(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] s;
    s = x >>> FRAC_BITS;
    if (s < 0) return 8'd0;
    if (s > 27'sd255) return 8'd255;
    return s[7:0];
  endfunction

  logic signed [PROD_W-1:0] y_s;
  logic signed [PROD_W-1:0] u_s;
  logic signed [PROD_W-1:0] v_s;
  logic signed [PROD_W-1:0] ys_q;
  logic signed [PROD_W-1:0] r_q;
  logic signed [PROD_W-1:0] g_q;
  logic signed [PROD_W-1:0] b_q;

  always_comb begin
    y_s  = $signed({{(PROD_W-8){1'b0}}, luma}) - $signed({{(PROD_W-8){1'b0}}, LUMA_OFFSET});
    u_s  = $signed({{(PROD_W-8){1'b0}}, chroma_u})
         - $signed({{(PROD_W-8){1'b0}}, CHROMA_OFFSET});
    v_s  = $signed({{(PROD_W-8){1'b0}}, chroma_v})
         - $signed({{(PROD_W-8){1'b0}}, CHROMA_OFFSET});
    ys_q = y_s <<< FRAC_BITS;
    r_q  = ys_q + COEF_RV * v_s;
    g_q  = ys_q - COEF_GU * u_s - COEF_GV * v_s;
    b_q  = ys_q + COEF_BU * u_s;
    pixel_word = {alpha_value, clamp_byte(r_q), clamp_byte(g_q), clamp_byte(b_q)};
  end

endmodule

`default_nettype wire

FILE: hdl/yuvargb_raster.sv
`timescale 1ns / 1ps
`default_nettype none

module yuvargb_raster
  import yuvargb_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire cfg_t    cfg,
  input  wire logic    step,
  output raster_t      cur
);

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int WDIM_W  = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W  = $clog2(MAX_HEIGHT + 1);

  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [CHROMA_W-1:0] chroma_pos_r, chroma_pos_nxt;
  logic [CHROMA_W-1:0] row_chroma_r, row_chroma_nxt;
  logic [ADDR_W-1:0]   fb_pos_r, fb_pos_nxt;

  logic [WDIM_W-1:0] w_eff;
  logic [HDIM_W-1:0] h_eff;
  logic              line_end;
  logic              frame_end;

  always_comb begin
    w_eff     = WDIM_W'(eff_dim(cfg.frame_width, DIM_FULL_W'(MAX_WIDTH)));
    h_eff     = HDIM_W'(eff_dim(cfg.frame_height, DIM_FULL_W'(MAX_HEIGHT)));
    line_end  = WDIM_W'(col_r) >= (w_eff - WDIM_W'(1));
    frame_end = line_end && (HDIM_W'(row_r) >= (h_eff - HDIM_W'(1)));
    cur.fb_address   = fb_pos_r;
    cur.chroma_index = chroma_pos_r;
    cur.frame_end    = frame_end;
  end

  always_comb begin
    col_nxt        = col_r;
    row_nxt        = row_r;
    chroma_pos_nxt = chroma_pos_r;
    row_chroma_nxt = row_chroma_r;
    fb_pos_nxt     = fb_pos_r;
    if (step) begin
      if (frame_end) begin
        col_nxt        = '0;
        row_nxt        = '0;
        chroma_pos_nxt = '0;
        row_chroma_nxt = '0;
        fb_pos_nxt     = '0;
      end else if (line_end) begin
        if (row_r[0]) begin
          row_chroma_nxt = row_chroma_r + CHROMA_W'(w_eff >> 1);
        end
        chroma_pos_nxt = row_chroma_nxt;
        fb_pos_nxt     = fb_pos_r + ADDR_W'(cfg.line_stride) - ADDR_W'(w_eff) + ADDR_W'(1);
        col_nxt        = '0;
        row_nxt        = row_r + ROW_W'(1);
      end else begin
        if (col_r[0]) begin
          chroma_pos_nxt = chroma_pos_r + CHROMA_W'(1);
        end
        fb_pos_nxt = fb_pos_r + ADDR_W'(1);
        col_nxt    = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      chroma_pos_r <= '0;
      row_chroma_r <= '0;
      fb_pos_r     <= '0;
    end else begin
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      chroma_pos_r <= chroma_pos_nxt;
      row_chroma_r <= row_chroma_nxt;
      fb_pos_r     <= fb_pos_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/yuv420_to_argb_pixel_stream.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload
// in_pix    sink       luma, chroma_u, chroma_v (8 bits each)
// out_pix   source     pixel_word (32), fb_address (25), chroma_index (22), frame_end (1)
// cfg_*     write      cfg_we, cfg_index (2), cfg_wdata (13)
//
// One pixel is accepted per clock while the output is not stalled; a result passes through
// the two-register pipeline: input register, then result register.
// Reset clears the raster counters and the pipeline valid flags, and loads the configuration
// registers with their default values.
// A stalled output holds its result while the input register can still take one more pixel if empty.

module yuv420_to_argb_pixel_stream
  import yuvargb_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  yuvargb_in_if.sink                 in_pix,
  yuvargb_out_if.source              out_pix,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t       cfg_r;
  logic [7:0] alpha_r;

  logic       a_valid_r;
  logic [7:0] a_luma_r;
  logic [7:0] a_u_r;
  logic [7:0] a_v_r;
  raster_t    a_rast_r;

  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;
  raster_t           out_rast_r;

  logic              advance;
  logic              in_fire;
  raster_t           rast_cur;
  logic [WORD_W-1:0] word_nxt;

  assign advance      = a_valid_r && (!out_valid_r || out_pix.ready);
  assign in_pix.ready = !a_valid_r || advance;
  assign in_fire      = in_pix.valid && in_pix.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= FRAME_WIDTH_RST;
      cfg_r.frame_height <= FRAME_HEIGHT_RST;
      cfg_r.line_stride  <= LINE_STRIDE_RST;
      alpha_r            <= ALPHA_VALUE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  cfg_r.frame_width  <= cfg_wdata;
        CFG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_wdata;
        CFG_LINE_STRIDE:  cfg_r.line_stride  <= cfg_wdata;
        CFG_ALPHA_VALUE:  alpha_r            <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  yuvargb_raster #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_raster (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .step  (in_fire),
    .cur   (rast_cur)
  );

  yuvargb_colour u_colour (
    .luma        (a_luma_r),
    .chroma_u    (a_u_r),
    .chroma_v    (a_v_r),
    .alpha_value (alpha_r),
    .pixel_word  (word_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_pix.ready) begin
        a_valid_r <= in_pix.valid;
      end
      if (!out_valid_r || out_pix.ready) begin
        out_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_luma_r <= in_pix.luma;
      a_u_r    <= in_pix.chroma_u;
      a_v_r    <= in_pix.chroma_v;
      a_rast_r <= rast_cur;
    end
    if (advance) begin
      out_word_r <= word_nxt;
      out_rast_r <= a_rast_r;
    end
  end

  assign out_pix.valid        = out_valid_r;
  assign out_pix.pixel_word   = out_word_r;
  assign out_pix.fb_address   = out_rast_r.fb_address;
  assign out_pix.chroma_index = out_rast_r.chroma_index;
  assign out_pix.frame_end    = out_rast_r.frame_end;

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && rast_cur.frame_end) |=>
      (rast_cur.fb_address == '0 && rast_cur.chroma_index == '0))
    else $error("raster counters did not restart after the last pixel");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("a staged pixel was lost on its way to the output register");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_pix.ready)
    else $error("input held off although the output register is empty");

endmodule

`default_nettype wire
